FILE: rtl/core/dsu_pkg.sv
package dsu_pkg;

	// fixed field widths of the item ports
	localparam int ELEM_W     = 8;
	localparam int FUNC_W     = 2;
	localparam int SIZE_OUT_W = 9;

	// default table depth
	localparam int NUM_ELEMS_DEF = 256;

	// fixed-point reciprocal used for index reduction
	localparam int RECIP_W = 16;

	// operation codes; any code other than merge behaves as a root lookup
	localparam logic [FUNC_W-1:0] FUNC_MERGE = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_SIZE  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd2;

endpackage

FILE: rtl/core/dsu_ram.sv
module dsu_ram #(
	parameter int DEPTH = dsu_pkg::NUM_ELEMS_DEF,
	parameter int WIDTH = dsu_pkg::ELEM_W,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/dsu_clip.sv
module dsu_clip #(
	parameter int NUM_ELEMS = dsu_pkg::NUM_ELEMS_DEF,
	localparam int IW = $clog2(NUM_ELEMS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [dsu_pkg::ELEM_W-1:0] raw_a,
	input  logic [dsu_pkg::ELEM_W-1:0] raw_b,
	output logic                       done,
	output logic [IW-1:0]              idx_a,
	output logic [IW-1:0]              idx_b
);

	localparam int EW = dsu_pkg::ELEM_W;
	localparam int RW = dsu_pkg::RECIP_W;
	localparam int PW = EW + RW;
	localparam int NW = RW + 1;
	localparam int QW = PW + 1;
	localparam logic [RW-1:0] RECIP = RW'((2 ** RW) / NUM_ELEMS);
	localparam logic [NW-1:0] NUM_W = NW'(NUM_ELEMS);

	logic          valid_s1;
	logic          valid_s2;
	logic [EW-1:0] raw_a_s1;
	logic [EW-1:0] raw_b_s1;
	logic [EW-1:0] quo_a_s1;
	logic [EW-1:0] quo_b_s1;
	logic [IW-1:0] idx_a_s2;
	logic [IW-1:0] idx_b_s2;

	logic [PW-1:0] prod_a;
	logic [PW-1:0] prod_b;
	logic [QW-1:0] back_a;
	logic [QW-1:0] back_b;
	logic [EW-1:0] rem_a;
	logic [EW-1:0] rem_b;
	logic [EW-1:0] fix_a;
	logic [EW-1:0] fix_b;

	// quotient estimate by reciprocal multiply, low by at most one
	always_comb begin
		prod_a = PW'(raw_a) * PW'(RECIP);
		prod_b = PW'(raw_b) * PW'(RECIP);
	end

	// remainder with a single correction step
	always_comb begin
		back_a = QW'(quo_a_s1) * QW'(NUM_W);
		back_b = QW'(quo_b_s1) * QW'(NUM_W);
		rem_a  = raw_a_s1 - back_a[EW-1:0];
		rem_b  = raw_b_s1 - back_b[EW-1:0];
		fix_a  = rem_a;
		fix_b  = rem_b;
		if (NW'(rem_a) >= NUM_W) begin
			fix_a = rem_a - NUM_W[EW-1:0];
		end
		if (NW'(rem_b) >= NUM_W) begin
			fix_b = rem_b - NUM_W[EW-1:0];
		end
	end

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	// data pipe
	always_ff @(posedge clk) begin
		raw_a_s1 <= raw_a;
		raw_b_s1 <= raw_b;
		quo_a_s1 <= prod_a[PW-1:RW];
		quo_b_s1 <= prod_b[PW-1:RW];
		idx_a_s2 <= IW'(fix_a);
		idx_b_s2 <= IW'(fix_b);
	end

	assign done  = valid_s2;
	assign idx_a = idx_a_s2;
	assign idx_b = idx_b_s2;

endmodule

FILE: rtl/core/disjoint_set_union_engine_unit.sv
// steps: index reduction, then a walk and a compression pass from elem_a and a size read;
// a merge adds a walk and a compression pass from elem_b and a join, then the output register
// throughput: one item at a time, set by the sequencer and the walks through the parent table
// compression points every node on a walked path straight at its root
// after reset a clearing pass initializes both tables, input stalled
module disjoint_set_union_engine_unit #(
	parameter int NUM_ELEMS = dsu_pkg::NUM_ELEMS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dsu_pkg::FUNC_W-1:0]     func,
	input  logic [dsu_pkg::ELEM_W-1:0]     elem_a,
	input  logic [dsu_pkg::ELEM_W-1:0]     elem_b,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dsu_pkg::ELEM_W-1:0]     root_out,
	output logic [dsu_pkg::SIZE_OUT_W-1:0] set_size,
	output logic                           already_joined
);

	localparam int IW = $clog2(NUM_ELEMS);
	localparam int SW = $clog2(NUM_ELEMS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ELEMS - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CLIP,
		S_WALK,
		S_COMP,
		S_SZA,
		S_SZB,
		S_PUT
	} state_t;

	state_t                         state_q;
	logic [IW-1:0]                  clr_q;
	logic [dsu_pkg::FUNC_W-1:0]     func_q;
	logic [IW-1:0]                  b_q;
	logic [IW-1:0]                  cur_q;
	logic [IW-1:0]                  start_q;
	logic [IW-1:0]                  node_q;
	logic [IW-1:0]                  root_q;
	logic [IW-1:0]                  ra_q;
	logic [IW-1:0]                  rb_q;
	logic                           on_b_q;
	logic                           joined_q;
	logic [SW-1:0]                  sza_q;
	logic [IW-1:0]                  res_root_q;
	logic [SW-1:0]                  res_size_q;
	logic                           res_join_q;
	logic                           out_valid_q;
	logic [dsu_pkg::ELEM_W-1:0]     root_out_q;
	logic [dsu_pkg::SIZE_OUT_W-1:0] set_size_q;
	logic                           joined_out_q;

	logic          clip_start;
	logic          clip_done;
	logic [IW-1:0] clip_a;
	logic [IW-1:0] clip_b;

	logic          p_we;
	logic [IW-1:0] p_waddr;
	logic [IW-1:0] p_wdata;
	logic [IW-1:0] p_raddr;
	logic [IW-1:0] p_rd;
	logic          s_we;
	logic [IW-1:0] s_waddr;
	logic [SW-1:0] s_wdata;
	logic [IW-1:0] s_raddr;
	logic [SW-1:0] s_rd;

	logic          is_merge;
	logic          a_small;
	logic [IW-1:0] big_root;
	logic [IW-1:0] small_root;
	logic [SW-1:0] sum_size;

	// index reduction unit
	dsu_clip #(
		.NUM_ELEMS(NUM_ELEMS)
	) u_clip (
		.clk   (clk),
		.arst_n(arst_n),
		.start (clip_start),
		.raw_a (elem_a),
		.raw_b (elem_b),
		.done  (clip_done),
		.idx_a (clip_a),
		.idx_b (clip_b)
	);

	// parent table
	dsu_ram #(
		.DEPTH(NUM_ELEMS),
		.WIDTH(IW)
	) u_parent (
		.clk  (clk),
		.we   (p_we),
		.waddr(p_waddr),
		.wdata(p_wdata),
		.raddr(p_raddr),
		.rdata(p_rd)
	);

	// size table, meaningful at roots only
	dsu_ram #(
		.DEPTH(NUM_ELEMS),
		.WIDTH(SW)
	) u_size (
		.clk  (clk),
		.we   (s_we),
		.waddr(s_waddr),
		.wdata(s_wdata),
		.raddr(s_raddr),
		.rdata(s_rd)
	);

	assign in_stall   = (state_q != S_IDLE);
	assign clip_start = (state_q == S_IDLE) && in_valid;
	assign is_merge   = (func_q == dsu_pkg::FUNC_MERGE);

	// union by size, tie keeps the first root
	assign a_small    = (sza_q < s_rd);
	assign big_root   = a_small ? rb_q : ra_q;
	assign small_root = a_small ? ra_q : rb_q;
	assign sum_size   = sza_q + s_rd;

	// table addressing per state
	always_comb begin
		p_we    = 1'b0;
		p_waddr = node_q;
		p_wdata = root_q;
		p_raddr = cur_q;
		s_we    = 1'b0;
		s_waddr = big_root;
		s_wdata = sum_size;
		s_raddr = ra_q;
		unique case (state_q)
			S_CLEAR: begin
				p_we    = 1'b1;
				p_waddr = clr_q;
				p_wdata = clr_q;
				s_we    = 1'b1;
				s_waddr = clr_q;
				s_wdata = SW'(1);
			end
			S_CLIP: begin
				p_raddr = clip_a;
			end
			S_WALK: begin
				p_raddr = (p_rd == cur_q) ? start_q : p_rd;
			end
			S_COMP: begin
				if (node_q != root_q) begin
					p_we    = 1'b1;
					p_raddr = p_rd;
				end else begin
					p_raddr = b_q;
					s_raddr = on_b_q ? ra_q : root_q;
				end
			end
			S_SZA: begin
				s_raddr = rb_q;
			end
			S_SZB: begin
				p_we    = 1'b1;
				p_waddr = small_root;
				p_wdata = big_root;
				s_we    = 1'b1;
				s_waddr = big_root;
				s_wdata = sum_size;
			end
			S_IDLE, S_PUT: begin
			end
			default: begin
			end
		endcase
	end

	// sequencer: clear, reduce, walk, compress, join, deliver
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			on_b_q      <= 1'b0;
			joined_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result taken while no new one is loaded
			if (out_valid_q && !out_stall && state_q != S_PUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IW'(1);
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func;
						state_q <= S_CLIP;
					end
				end
				S_CLIP: begin
					if (clip_done) begin
						b_q      <= clip_b;
						cur_q    <= clip_a;
						start_q  <= clip_a;
						on_b_q   <= 1'b0;
						joined_q <= 1'b0;
						state_q  <= S_WALK;
					end
				end
				S_WALK: begin
					if (p_rd == cur_q) begin
						root_q  <= cur_q;
						node_q  <= start_q;
						state_q <= S_COMP;
					end else begin
						cur_q <= p_rd;
					end
				end
				S_COMP: begin
					if (node_q != root_q) begin
						node_q <= p_rd;
					end else if (!on_b_q) begin
						ra_q <= root_q;
						if (is_merge) begin
							on_b_q  <= 1'b1;
							cur_q   <= b_q;
							start_q <= b_q;
							state_q <= S_WALK;
						end else begin
							state_q <= S_SZA;
						end
					end else begin
						rb_q     <= root_q;
						joined_q <= (root_q == ra_q);
						state_q  <= S_SZA;
					end
				end
				S_SZA: begin
					sza_q <= s_rd;
					if (is_merge && !joined_q) begin
						state_q <= S_SZB;
					end else begin
						res_root_q <= ra_q;
						res_size_q <= s_rd;
						res_join_q <= joined_q;
						state_q    <= S_PUT;
					end
				end
				S_SZB: begin
					res_root_q <= big_root;
					res_size_q <= sum_size;
					res_join_q <= 1'b0;
					state_q    <= S_PUT;
				end
				S_PUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						root_out_q   <= dsu_pkg::ELEM_W'(res_root_q);
						set_size_q   <= dsu_pkg::SIZE_OUT_W'(res_size_q);
						joined_out_q <= res_join_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign root_out       = root_out_q;
	assign set_size       = set_size_q;
	assign already_joined = joined_out_q;

`ifndef SYNTHESIS
	// reduced indices arrive through the clip unit's valid_s1 and valid_s2 registers after an item is taken
	a_clip_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid) |=> ##1 clip_done)
		else $error("index reduction did not finish in two cycles");

	// compression never writes the entry being fetched next
	a_comp_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMP && p_we) |-> (p_waddr != p_raddr))
		else $error("compression write collides with next read");

	// merged set never exceeds the element count
	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SZB) |-> ((32'(sza_q) + 32'(s_rd)) <= 32'(NUM_ELEMS)))
		else $error("merged set size overflow");

	// joined flag only comes from a merge
	a_join_merge: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SZA && joined_q) |-> is_merge)
		else $error("joined flag on non-merge item");

	// a new item is taken only once the previous one left the sequencer
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_CLIP))
		else $error("item taken outside idle");
`endif

endmodule

FILE: verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [dsu_pkg::FUNC_W-1:0]     func_t;
	typedef logic [dsu_pkg::ELEM_W-1:0]     elem_t;
	typedef logic [dsu_pkg::SIZE_OUT_W-1:0] setsz_t;

	// spare operation code, handled by the block as a root lookup
	localparam func_t FUNC_SPARE = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_PRINTS  = 100;

	typedef struct packed {
		elem_t  root;
		setsz_t size;
		logic   joined;
	} set_answer_t;

	logic   clk;
	logic   arst_n    = 1'b0;
	logic   in_valid  = 1'b0;
	logic   in_stall;
	func_t  func      = dsu_pkg::FUNC_FIND;
	elem_t  elem_a    = '0;
	elem_t  elem_b    = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	elem_t  root_out;
	setsz_t set_size;
	logic   already_joined;

	// shadow union-find tables
	elem_t  parent_tbl [dsu_pkg::NUM_ELEMS_DEF];
	setsz_t size_tbl   [dsu_pkg::NUM_ELEMS_DEF];

	set_answer_t answer_q [$];
	int          err_cnt       = 0;
	int          cycle_cnt     = 0;
	int          rx_burst_left = 0;
	logic        rx_hold       = 1'b0;
	logic        rx_idle_en    = 1'b1;
	logic        tx_idle_en    = 1'b1;

	disjoint_set_union_engine_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.func           (func),
		.elem_a         (elem_a),
		.elem_b         (elem_b),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.root_out       (root_out),
		.set_size       (set_size),
		.already_joined (already_joined)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// every element starts as its own singleton set
	function automatic void uf_reset();
		for (int i = 0; i < dsu_pkg::NUM_ELEMS_DEF; i++) begin
			parent_tbl[i] = elem_t'(i);
			size_tbl[i]   = setsz_t'(1);
		end
	endfunction

	// walk to the root, then point every node on the path at it
	function automatic elem_t uf_find_compress(input elem_t e);
		elem_t r;
		elem_t n;
		elem_t nxt;
		r = e;
		while (parent_tbl[r] != r)
			r = parent_tbl[r];
		n = e;
		while (n != r) begin
			nxt = parent_tbl[n];
			parent_tbl[n] = r;
			n = nxt;
		end
		return r;
	endfunction

	// apply one operation to the shadow tables and return its answer
	function automatic set_answer_t uf_apply_op(input func_t f, input elem_t a,
			input elem_t b);
		set_answer_t ans;
		elem_t       ra;
		elem_t       rb;
		elem_t       tmp;
		ans.joined = 1'b0;
		ra = uf_find_compress(a);
		if (f == dsu_pkg::FUNC_MERGE) begin
			rb = uf_find_compress(b);
			if (ra == rb) begin
				ans.joined = 1'b1;
			end else begin
				// smaller set goes under the larger; ties keep the first root
				if (size_tbl[ra] < size_tbl[rb]) begin
					tmp = ra;
					ra  = rb;
					rb  = tmp;
				end
				parent_tbl[rb] = ra;
				size_tbl[ra]   = size_tbl[ra] + size_tbl[rb];
			end
		end
		ans.root = ra;
		ans.size = size_tbl[ra];
		return ans;
	endfunction

	task automatic report_mismatch(input string msg);
		if (err_cnt < MAX_PRINTS)
			$display("MISMATCH @%0t: %s", $time, msg);
		err_cnt++;
	endtask

	// offer one item, with an optional gap first, and record its answer once taken
	task automatic send_item(input func_t f, input elem_t a, input elem_t b);
		if (tx_idle_en && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		elem_a   <= a;
		elem_b   <= b;
		do @(posedge clk); while (in_stall);
		answer_q = {answer_q, uf_apply_op(f, a, b)};
	endtask

	function automatic elem_t rand_elem();
		case ($urandom_range(0, 31))
			0:       return '0;
			1:       return '1;
			default: return elem_t'($urandom_range(0, dsu_pkg::NUM_ELEMS_DEF - 1));
		endcase
	endfunction

	function automatic func_t rand_func();
		int r;
		r = int'($urandom_range(0, 9));
		if (r < 4)
			return dsu_pkg::FUNC_MERGE;
		else if (r < 6)
			return dsu_pkg::FUNC_SIZE;
		else if (r < 9)
			return dsu_pkg::FUNC_FIND;
		else
			return FUNC_SPARE;
	endfunction

	// output side: random stall bursts plus the long hold-off
	always @(posedge clk) begin
		if (rx_burst_left > 0)
			rx_burst_left--;
		else if (rx_idle_en && $urandom_range(0, 11) == 0)
			rx_burst_left = $urandom_range(1, 18);
		out_stall <= rx_hold || (rx_burst_left > 0);
	end

	// compare each taken result with the oldest pending answer
	always @(posedge clk) begin
		set_answer_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (answer_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result root=%0d size=%0d joined=%0b",
					root_out, set_size, already_joined));
			end else begin
				exp_r = answer_q.pop_front();
				if (root_out !== exp_r.root)
					report_mismatch($sformatf("root_out got %0d want %0d",
						root_out, exp_r.root));
				if (set_size !== exp_r.size)
					report_mismatch($sformatf("set_size got %0d want %0d",
						set_size, exp_r.size));
				if (already_joined !== exp_r.joined)
					report_mismatch($sformatf("already_joined got %0b want %0b",
						already_joined, exp_r.joined));
			end
		end
	end

	// field extremes, every operation, self merge, ties and size ordering
	task automatic test_directed_ops();
		send_item(dsu_pkg::FUNC_FIND,  8'd0,   8'd255);
		send_item(dsu_pkg::FUNC_FIND,  8'd255, 8'd0);
		send_item(dsu_pkg::FUNC_SIZE,  8'd128, 8'd127);
		send_item(FUNC_SPARE,          8'd77,  8'd255);
		send_item(dsu_pkg::FUNC_MERGE, 8'd5,   8'd5);
		send_item(dsu_pkg::FUNC_MERGE, 8'd0,   8'd255);
		send_item(dsu_pkg::FUNC_MERGE, 8'd255, 8'd0);
		send_item(dsu_pkg::FUNC_SIZE,  8'd255, 8'd0);
		send_item(dsu_pkg::FUNC_MERGE, 8'd1,   8'd2);
		send_item(dsu_pkg::FUNC_MERGE, 8'd3,   8'd1);
		send_item(dsu_pkg::FUNC_MERGE, 8'd0,   8'd3);
		send_item(dsu_pkg::FUNC_FIND,  8'd255, 8'd255);
		send_item(FUNC_SPARE,          8'd2,   8'd0);
		send_item(dsu_pkg::FUNC_SIZE,  8'd0,   8'd255);
		send_item(dsu_pkg::FUNC_MERGE, 8'd170, 8'd85);
		send_item(dsu_pkg::FUNC_MERGE, 8'd85,  8'd170);
		send_item(dsu_pkg::FUNC_MERGE, 8'd254, 8'd85);
		send_item(dsu_pkg::FUNC_SIZE,  8'd170, 8'd0);
		send_item(dsu_pkg::FUNC_MERGE, 8'd170, 8'd255);
		send_item(dsu_pkg::FUNC_FIND,  8'd254, 8'd1);
		send_item(FUNC_SPARE,          8'd5,   8'd5);
	endtask

	// pairwise merges of growing groups build the deepest trees union by size allows
	task automatic test_deep_trees();
		int    span;
		elem_t a;
		elem_t b;
		elem_t t;
		func_t f;
		for (int base = 0; base < dsu_pkg::NUM_ELEMS_DEF; base += 32) begin
			span = 1;
			while (span < 32) begin
				for (int i = 0; i < 32; i += 2 * span) begin
					a = elem_t'(base + i);
					b = elem_t'(base + i + span);
					if ($urandom_range(0, 1)) begin
						t = a;
						a = b;
						b = t;
					end
					send_item(dsu_pkg::FUNC_MERGE, a, b);
					// occasional lookup noise inside the group
					if ($urandom_range(0, 9) == 0)
						send_item(dsu_pkg::FUNC_FIND,
							elem_t'(base + int'($urandom_range(0, 31))), rand_elem());
				end
				span = span * 2;
			end
			for (int q = 0; q < 12; q++) begin
				f = ($urandom_range(0, 2) == 0) ? dsu_pkg::FUNC_SIZE :
					($urandom_range(0, 3) == 0) ? FUNC_SPARE : dsu_pkg::FUNC_FIND;
				send_item(f, elem_t'(base + int'($urandom_range(0, 31))), rand_elem());
			end
		end
	endtask

	// receiver holds off for a long stretch while items keep coming
	task automatic test_output_hold_off();
		fork
			begin
				rx_hold <= 1'b1;
				repeat (300) @(posedge clk);
				rx_hold <= 1'b0;
			end
			begin
				for (int i = 0; i < 30; i++)
					send_item(rand_func(), rand_elem(), rand_elem());
			end
		join
	endtask

	// mixed random traffic with idling switched per stretch
	task automatic test_random_mix();
		for (int i = 0; i < 800; i++) begin
			if (i % 100 == 0) begin
				tx_idle_en <= ($urandom_range(0, 3) != 0);
				rx_idle_en <= ($urandom_range(0, 3) != 0);
			end
			send_item(rand_func(), rand_elem(), rand_elem());
		end
	endtask

	// back-to-back traffic with no idling on either side
	task automatic test_no_idle_tail();
		tx_idle_en <= 1'b0;
		rx_idle_en <= 1'b0;
		for (int i = 0; i < 300; i++)
			send_item(rand_func(), rand_elem(), rand_elem());
	endtask

	// watchdog
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// test sequence
	initial begin
		uf_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_ops();
		test_deep_trees();
		test_output_hold_off();
		test_random_mix();
		test_no_idle_tail();
		in_valid <= 1'b0;
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (err_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
